/* design/amcb_pkg.sv */
// ----------------------------------------------------------------------------
// Alpha mask color blend package
// Shared register map, configuration and transaction types, blend constants.
// ----------------------------------------------------------------------------
package amcb_pkg;

  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;

  localparam int unsigned NumLanes = 4;
  localparam int unsigned LaneB    = 0;
  localparam int unsigned LaneG    = 1;
  localparam int unsigned LaneR    = 2;
  localparam int unsigned LaneA    = 3;

  localparam int unsigned QDepth = 2;

  localparam logic [15:0] FullScale = 16'hFE01;
  localparam logic [16:0] RecipMul  = 17'd66051;
  localparam logic [7:0]  AlphaTint = 8'hFF;

  typedef enum logic [2:0] {
    REG_DST_WIDTH  = 3'd0,
    REG_DST_HEIGHT = 3'd1,
    REG_DST_STRIDE = 3'd2,
    REG_SRC_SIZE   = 3'd3,
    REG_SRC_STRIDE = 3'd4,
    REG_ORIGIN     = 3'd5,
    REG_COLOR_ARGB = 3'd6,
    REG_MODE       = 3'd7
  } amcb_reg_e;

  typedef struct packed {
    logic [12:0] dst_width;
    logic [12:0] dst_height;
    logic [14:0] dst_stride;
    logic [28:0] src_size;
    logic [12:0] src_stride;
    logic [31:0] origin;
    logic [31:0] color_argb;
    logic [2:0]  mode;
  } amcb_cfg_t;

  typedef struct packed {
    logic [7:0]                coverage;
    logic [NumLanes-1:0][7:0]  dst_chan;
    logic                      write_enable;
    logic                      last_pixel;
    logic [12:0]               pos_x;
    logic [12:0]               pos_y;
    logic [23:0]               src_x;
    logic [23:0]               src_y;
  } amcb_item_t;

  typedef struct packed {
    logic        write_enable;
    logic        last_pixel;
    logic [25:0] dst_offset;
    logic [23:0] next_src_offset;
  } amcb_tag_t;

endpackage

/* design/alpha_mask_color_blend.sv */
// ----------------------------------------------------------------------------
// Alpha mask color blend top level
// Tinted coverage-mask blit onto a BGR24 or BGRA32 destination.
// ----------------------------------------------------------------------------
// Each input transaction is one mask pixel in raster order with the current
// destination channels; each produces exactly one result with the clipped
// destination offset, the blended channels and the mask offset for the next
// pixel. The front end classifies a pixel in the cycle it is accepted and
// places it in a two-entry queue; the back end is a five-stage pipeline
// (alpha and offset products, channel products, sum, reciprocal estimate,
// one-step correction of the divide by 65025). Sustained throughput is one
// transaction per clock while no result is stalled, limited by the back-end
// pipeline advancing once per cycle. A stalled result holds the whole back
// end, and input stall rises once the queue is full. Configuration must be
// written through the APB-style port only while no transaction is in flight;
// the block does not enforce this. The position counters run across blits and
// wrap after the last mask pixel. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module alpha_mask_color_blend #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [amcb_pkg::ApbAddrW-1:0]   paddr,
  input  logic [amcb_pkg::ApbDataW-1:0]   pwdata,
  output logic [amcb_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      coverage_i,
  input  logic [7:0]                      dst_blue_i,
  input  logic [7:0]                      dst_green_i,
  input  logic [7:0]                      dst_red_i,
  input  logic [7:0]                      dst_alpha_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            write_enable_o,
  output logic [25:0]                     dst_offset_o,
  output logic [7:0]                      out_blue_o,
  output logic [7:0]                      out_green_o,
  output logic [7:0]                      out_red_o,
  output logic [7:0]                      out_alpha_o,
  output logic [23:0]                     next_src_offset_o,
  output logic                            last_pixel_o
);

  amcb_pkg::amcb_cfg_t  cfg;
  amcb_pkg::amcb_item_t front_item, queue_item;
  logic                 push, pop, q_full, q_valid;

  amcb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  amcb_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .coverage_i  (coverage_i),
    .dst_blue_i  (dst_blue_i),
    .dst_green_i (dst_green_i),
    .dst_red_i   (dst_red_i),
    .dst_alpha_i (dst_alpha_i),
    .full_i      (q_full),
    .push_o      (push),
    .item_o      (front_item)
  );

  amcb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (queue_item)
  );

  amcb_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .q_valid_i         (q_valid),
    .q_item_i          (queue_item),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .write_enable_o    (write_enable_o),
    .dst_offset_o      (dst_offset_o),
    .out_blue_o        (out_blue_o),
    .out_green_o       (out_green_o),
    .out_red_o         (out_red_o),
    .out_alpha_o       (out_alpha_o),
    .next_src_offset_o (next_src_offset_o),
    .last_pixel_o      (last_pixel_o)
  );

endmodule

/* design/amcb_regs.sv */
// ----------------------------------------------------------------------------
// Alpha mask color blend register file
// APB-style configuration registers with combinational read back.
// ----------------------------------------------------------------------------
module amcb_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [amcb_pkg::ApbAddrW-1:0]   paddr,
  input  logic [amcb_pkg::ApbDataW-1:0]   pwdata,
  output logic [amcb_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready,
  output amcb_pkg::amcb_cfg_t             cfg_o
);

  amcb_pkg::amcb_cfg_t cfg_q, cfg_d;
  amcb_pkg::amcb_reg_e reg_idx;
  logic                wr_en;

  assign reg_idx = amcb_pkg::amcb_reg_e'(paddr[4:2]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        amcb_pkg::REG_DST_WIDTH:  cfg_d.dst_width  = pwdata[12:0];
        amcb_pkg::REG_DST_HEIGHT: cfg_d.dst_height = pwdata[12:0];
        amcb_pkg::REG_DST_STRIDE: cfg_d.dst_stride = pwdata[14:0];
        amcb_pkg::REG_SRC_SIZE:   cfg_d.src_size   = pwdata[28:0];
        amcb_pkg::REG_SRC_STRIDE: cfg_d.src_stride = pwdata[12:0];
        amcb_pkg::REG_ORIGIN:     cfg_d.origin     = pwdata;
        amcb_pkg::REG_COLOR_ARGB: cfg_d.color_argb = pwdata;
        amcb_pkg::REG_MODE:       cfg_d.mode       = pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      amcb_pkg::REG_DST_WIDTH:  prdata = 32'(cfg_q.dst_width);
      amcb_pkg::REG_DST_HEIGHT: prdata = 32'(cfg_q.dst_height);
      amcb_pkg::REG_DST_STRIDE: prdata = 32'(cfg_q.dst_stride);
      amcb_pkg::REG_SRC_SIZE:   prdata = 32'(cfg_q.src_size);
      amcb_pkg::REG_SRC_STRIDE: prdata = 32'(cfg_q.src_stride);
      amcb_pkg::REG_ORIGIN:     prdata = cfg_q.origin;
      amcb_pkg::REG_COLOR_ARGB: prdata = cfg_q.color_argb;
      amcb_pkg::REG_MODE:       prdata = 32'(cfg_q.mode);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* design/amcb_front.sv */
// ----------------------------------------------------------------------------
// Alpha mask color blend front end
// Accepts mask pixels, tracks the raster position, clips and mirrors.
// ----------------------------------------------------------------------------
module amcb_front #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  amcb_pkg::amcb_cfg_t   cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            coverage_i,
  input  logic [7:0]            dst_blue_i,
  input  logic [7:0]            dst_green_i,
  input  logic [7:0]            dst_red_i,
  input  logic [7:0]            dst_alpha_i,
  input  logic                  full_i,
  output logic                  push_o,
  output amcb_pkg::amcb_item_t  item_o
);

  localparam int unsigned CntW   = $clog2(MAX_DIM + 1);
  localparam logic [16:0] MaxDim = 17'(MAX_DIM);

  logic [CntW-1:0] column_q, column_d, row_q, row_d;
  logic [CntW-1:0] col_next, row_next;
  logic [16:0]     w_raw, h_raw, w_dim, h_dim;
  logic            col_end, row_end;
  logic [17:0]     pos_x, pos_y;
  logic            on_dst;

  assign w_raw = {4'b0, cfg_i.src_size[28:16]};
  assign h_raw = {1'b0, cfg_i.src_size[15:0]};
  assign w_dim = (w_raw > MaxDim) ? MaxDim : w_raw;
  assign h_dim = (h_raw > MaxDim) ? MaxDim : h_raw;

  assign col_end = (17'(column_q) + 17'd1) >= w_dim;
  assign row_end = (17'(row_q) + 17'd1) >= h_dim;

  always_comb begin
    col_next = column_q + CntW'(1);
    row_next = row_q;
    if (col_end) begin
      col_next = '0;
      row_next = row_end ? '0 : row_q + CntW'(1);
    end
  end

  assign pos_x = 18'(column_q) + {{2{cfg_i.origin[31]}}, cfg_i.origin[31:16]};
  assign pos_y = 18'(row_q) + {{2{cfg_i.origin[15]}}, cfg_i.origin[15:0]};
  assign on_dst = !pos_x[17] && !pos_y[17]
               && (pos_x[16:0] < {4'b0, cfg_i.dst_width})
               && (pos_y[16:0] < {4'b0, cfg_i.dst_height});

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    item_o                            = '0;
    item_o.coverage                   = coverage_i;
    item_o.dst_chan[amcb_pkg::LaneB]  = dst_blue_i;
    item_o.dst_chan[amcb_pkg::LaneG]  = dst_green_i;
    item_o.dst_chan[amcb_pkg::LaneR]  = dst_red_i;
    item_o.dst_chan[amcb_pkg::LaneA]  = dst_alpha_i;
    item_o.write_enable               = on_dst;
    item_o.last_pixel                 = col_end && row_end;
    item_o.pos_x                      = pos_x[12:0];
    item_o.pos_y                      = pos_y[12:0];
    item_o.src_x = cfg_i.mode[1] ? 24'(w_dim) - 24'(col_next) - 24'd1 : 24'(col_next);
    item_o.src_y = cfg_i.mode[2] ? 24'(h_dim) - 24'(row_next) - 24'd1 : 24'(row_next);
  end

  always_comb begin
    column_d = column_q;
    row_d    = row_q;
    if (push_o) begin
      column_d = col_next;
      row_d    = row_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
      row_q    <= '0;
    end else begin
      column_q <= column_d;
      row_q    <= row_d;
    end
  end

endmodule

/* design/amcb_queue.sv */
// ----------------------------------------------------------------------------
// Alpha mask color blend queue
// Short FIFO of classified transactions between front end and back end.
// ----------------------------------------------------------------------------
module amcb_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  amcb_pkg::amcb_item_t  item_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output amcb_pkg::amcb_item_t  item_o
);

  localparam int unsigned Depth = amcb_pkg::QDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  amcb_pkg::amcb_item_t slot_q [Depth];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      count_q, count_d;

  assign full_o  = count_q == CntW'(Depth);
  assign valid_o = count_q != '0;
  assign item_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count exceeds depth");

  pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from empty queue");

  push_grows_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> count_q == $past(count_q) + CntW'(1))
    else $error("push without pop did not grow the queue");

endmodule

/* design/amcb_back.sv */
// ----------------------------------------------------------------------------
// Alpha mask color blend back end
// Five-stage blend pipeline: offsets, products, sum, divide by 65025.
// ----------------------------------------------------------------------------
module amcb_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  amcb_pkg::amcb_cfg_t   cfg_i,
  input  logic                  q_valid_i,
  input  amcb_pkg::amcb_item_t  q_item_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  write_enable_o,
  output logic [25:0]           dst_offset_o,
  output logic [7:0]            out_blue_o,
  output logic [7:0]            out_green_o,
  output logic [7:0]            out_red_o,
  output logic [7:0]            out_alpha_o,
  output logic [23:0]           next_src_offset_o,
  output logic                  last_pixel_o
);

  localparam int unsigned NumStages = 5;
  localparam int unsigned Lanes     = amcb_pkg::NumLanes;

  logic [NumStages-1:0] vld_q, vld_d;
  logic                 adv;

  amcb_pkg::amcb_tag_t  tag_q [NumStages];
  amcb_pkg::amcb_tag_t  tag_d;

  logic [15:0]            s1_a_q, s1_a_d;
  logic [Lanes-1:0][7:0]  s1_d_q;
  logic [27:0]            row_ofs;
  logic [14:0]            col_ofs;
  logic [36:0]            src_row;

  logic [Lanes-1:0][7:0]  tint;
  logic [Lanes-1:0][23:0] s2_p0_q, s2_p0_d, s2_p1_q, s2_p1_d;
  logic [Lanes-1:0][23:0] s3_v_q, s3_v_d, s4_v_q;
  logic [Lanes-1:0][7:0]  s4_q0_q, s4_q0_d;
  logic [Lanes-1:0][40:0] recip_prod;
  logic [Lanes-1:0][23:0] rem;
  logic [Lanes-1:0][7:0]  s5_c_q, s5_c_d;

  assign adv   = !(vld_q[NumStages-1] && out_stall_i);
  assign pop_o = q_valid_i && adv;
  assign vld_d = {vld_q[NumStages-2:0], pop_o};

  // stage 1: coverage alpha and both byte offsets
  assign s1_a_d  = 16'(q_item_i.coverage) * 16'(cfg_i.color_argb[31:24]);
  assign row_ofs = 28'(q_item_i.pos_y) * 28'(cfg_i.dst_stride);
  assign col_ofs = cfg_i.mode[0] ? {q_item_i.pos_x, 2'b0}
                                 : 15'(q_item_i.pos_x) + {1'b0, q_item_i.pos_x, 1'b0};
  assign src_row = 37'(q_item_i.src_y) * 37'(cfg_i.src_stride);

  always_comb begin
    tag_d                 = '0;
    tag_d.write_enable    = q_item_i.write_enable;
    tag_d.last_pixel      = q_item_i.last_pixel;
    tag_d.dst_offset      = q_item_i.write_enable ? 26'(row_ofs + 28'(col_ofs)) : '0;
    tag_d.next_src_offset = src_row[23:0] + q_item_i.src_x;
  end

  // stage 2: weighted destination and tint products
  assign tint = {amcb_pkg::AlphaTint, cfg_i.color_argb[23:16],
                 cfg_i.color_argb[15:8], cfg_i.color_argb[7:0]};

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      s2_p0_d[l] = 24'(amcb_pkg::FullScale - s1_a_q) * 24'(s1_d_q[l]);
      s2_p1_d[l] = 24'(tint[l]) * 24'(s1_a_q);
    end
  end

  // stage 3: sum, stage 4: reciprocal estimate, stage 5: correct by one
  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      s3_v_d[l]     = s2_p0_q[l] + s2_p1_q[l];
      recip_prod[l] = 41'(s3_v_q[l]) * 41'(amcb_pkg::RecipMul);
      s4_q0_d[l]    = recip_prod[l][39:32];
      rem[l]        = s4_v_q[l] - 24'(s4_q0_q[l]) * 24'(amcb_pkg::FullScale);
      s5_c_d[l]     = s4_q0_q[l] + 8'(rem[l] >= 24'(amcb_pkg::FullScale));
      if (!tag_q[3].write_enable) begin
        s5_c_d[l] = '0;
      end
    end
    if (!cfg_i.mode[0]) begin
      s5_c_d[amcb_pkg::LaneA] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_a_q   <= s1_a_d;
      s1_d_q   <= q_item_i.dst_chan;
      tag_q[0] <= tag_d;
      for (int s = 1; s < NumStages; s++) begin
        tag_q[s] <= tag_q[s-1];
      end
      s2_p0_q <= s2_p0_d;
      s2_p1_q <= s2_p1_d;
      s3_v_q  <= s3_v_d;
      s4_v_q  <= s3_v_q;
      s4_q0_q <= s4_q0_d;
      s5_c_q  <= s5_c_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  assign out_valid_o       = vld_q[NumStages-1];
  assign write_enable_o    = tag_q[NumStages-1].write_enable;
  assign dst_offset_o      = tag_q[NumStages-1].dst_offset;
  assign next_src_offset_o = tag_q[NumStages-1].next_src_offset;
  assign last_pixel_o      = tag_q[NumStages-1].last_pixel;
  assign out_blue_o        = s5_c_q[amcb_pkg::LaneB];
  assign out_green_o       = s5_c_q[amcb_pkg::LaneG];
  assign out_red_o         = s5_c_q[amcb_pkg::LaneR];
  assign out_alpha_o       = s5_c_q[amcb_pkg::LaneA];

  stall_holds_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NumStages-1] && out_stall_i |=> vld_q[NumStages-1])
    else $error("stalled result dropped");

  clipped_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NumStages-1] && !tag_q[NumStages-1].write_enable |->
      dst_offset_o == '0 && s5_c_q == '0)
    else $error("clipped pixel carries nonzero data");

  result_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(vld_q[NumStages-1]) |-> $past(vld_q[NumStages-2]))
    else $error("result appeared without a transaction behind it");

endmodule
